@@ rtl/core/bc_pkg.sv @@
`default_nettype none

package bc_pkg;

    // Register indexes on the configuration channel
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

    localparam logic [15:0] RST_SENS        = 16'd40127;
    localparam logic [15:0] RST_OFFSET      = 16'd36924;
    localparam logic [15:0] RST_SENS_TEMP   = 16'd23317;
    localparam logic [15:0] RST_OFFSET_TEMP = 16'd23282;
    localparam logic [15:0] RST_REF_TEMP    = 16'd33464;
    localparam logic [15:0] RST_TEMP_SLOPE  = 16'd28312;

    localparam int TEMP_BASE = 2000;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;

    // Edges from an accepted start to the edge that accepts its result
    localparam int LATENCY = 9;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] offset;
        logic [15:0] sens_temp;
        logic [15:0] offset_temp;
        logic [15:0] ref_temp;
        logic [15:0] temp_slope;
    } bc_cfg_t;

    // First-order terms
    typedef struct packed {
        logic signed [19:0] temp;
        logic signed [18:0] dev;     // temp - 2000
        logic signed [39:0] off;
        logic signed [37:0] sens;
        logic        [17:0] dtsq;    // dT*dT / 2^31
        logic        [23:0] raw_p;
    } bc_first_t;

    // Terms after the low-temperature correction
    typedef struct packed {
        logic signed [19:0] temp;
        logic signed [39:0] off;
        logic signed [37:0] sens;
        logic        [23:0] raw_p;
    } bc_second_t;

endpackage

`default_nettype wire

@@ rtl/core/bc_cfg_regs.sv @@
`default_nettype none

module bc_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                  cfg_data,
    output bc_pkg::bc_cfg_t                   cfg
);
    import bc_pkg::*;

    bc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sens        <= RST_SENS;
            cfg_reg.offset      <= RST_OFFSET;
            cfg_reg.sens_temp   <= RST_SENS_TEMP;
            cfg_reg.offset_temp <= RST_OFFSET_TEMP;
            cfg_reg.ref_temp    <= RST_REF_TEMP;
            cfg_reg.temp_slope  <= RST_TEMP_SLOPE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SENS:        cfg_reg.sens        <= cfg_data;
                REG_OFFSET:      cfg_reg.offset      <= cfg_data;
                REG_SENS_TEMP:   cfg_reg.sens_temp   <= cfg_data;
                REG_OFFSET_TEMP: cfg_reg.offset_temp <= cfg_data;
                REG_REF_TEMP:    cfg_reg.ref_temp    <= cfg_data;
                REG_TEMP_SLOPE:  cfg_reg.temp_slope  <= cfg_data;
                default:         ; // drop writes to unused indexes
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bc_first_order.sv @@
`default_nettype none

module bc_first_order (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire bc_pkg::bc_cfg_t cfg,
    input  wire logic        in_valid,
    input  wire logic [23:0] raw_t,
    input  wire logic [23:0] raw_p,
    output logic             out_valid,
    output bc_pkg::bc_first_t out_data
);
    import bc_pkg::*;

    // Stage 1: dT
    logic signed [24:0] dt_next;
    logic signed [24:0] s1_dt_reg;
    logic        [23:0] s1_rawp_reg;
    logic               s1_valid_reg;

    // Stage 2: products of dT
    logic signed [41:0] p6_next, p4_next, p3_next;
    logic signed [49:0] pdd_next;
    logic signed [41:0] s2_p6_reg, s2_p4_reg, s2_p3_reg;
    logic signed [49:0] s2_pdd_reg;
    logic        [23:0] s2_rawp_reg;
    logic               s2_valid_reg;

    // Stage 3: truncated quotients and first-order sums
    logic signed [41:0] p6_bias, p4_bias, p3_bias;
    logic signed [18:0] q6;
    logic signed [34:0] q4;
    logic signed [33:0] q3;
    bc_first_t          s3_next;
    bc_first_t          s3_data_reg;
    logic               s3_valid_reg;

    assign dt_next = $signed({1'b0, raw_t}) - $signed({1'b0, cfg.ref_temp, 8'h00});

    assign p6_next  = s1_dt_reg * $signed({1'b0, cfg.temp_slope});
    assign p4_next  = s1_dt_reg * $signed({1'b0, cfg.offset_temp});
    assign p3_next  = s1_dt_reg * $signed({1'b0, cfg.sens_temp});
    assign pdd_next = s1_dt_reg * s1_dt_reg;

    // Bias negative values so the shift truncates toward zero
    assign p6_bias = s2_p6_reg + $signed({19'd0, {23{s2_p6_reg[41]}}});
    assign p4_bias = s2_p4_reg + $signed({35'd0, {7{s2_p4_reg[41]}}});
    assign p3_bias = s2_p3_reg + $signed({34'd0, {8{s2_p3_reg[41]}}});
    assign q6 = p6_bias[41:23];
    assign q4 = p4_bias[41:7];
    assign q3 = p3_bias[41:8];

    always_comb
    begin
        s3_next.dev   = q6;
        s3_next.temp  = 20'(TEMP_BASE) + {q6[18], q6};
        s3_next.off   = $signed({8'd0, cfg.offset, 16'd0}) + {{5{q4[34]}}, q4};
        s3_next.sens  = $signed({7'd0, cfg.sens, 15'd0}) + {{4{q3[33]}}, q3};
        s3_next.dtsq  = s2_pdd_reg[48:31];
        s3_next.raw_p = s2_rawp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dt_reg   <= dt_next;
        s1_rawp_reg <= raw_p;
        s2_p6_reg   <= p6_next;
        s2_p4_reg   <= p4_next;
        s2_p3_reg   <= p3_next;
        s2_pdd_reg  <= pdd_next;
        s2_rawp_reg <= s1_rawp_reg;
        s3_data_reg <= s3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/bc_second_order.sv @@
`default_nettype none

module bc_second_order (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire bc_pkg::bc_first_t in_data,
    output logic               out_valid,
    output bc_pkg::bc_second_t out_data
);
    import bc_pkg::*;

    // Stage 4: square of the deviation from 20 degC
    logic signed [37:0] sq_full;
    logic        [34:0] sq_next;
    logic        [34:0] s4_sq_reg;
    bc_first_t          s4_data_reg;
    logic               s4_valid_reg;

    // Stage 5: apply the correction below 20 degC
    logic        [36:0] five_sq;
    logic               low;
    bc_second_t         s5_next;
    bc_second_t         s5_data_reg;
    logic               s5_valid_reg;

    assign sq_full = in_data.dev * in_data.dev;
    assign sq_next = sq_full[34:0];

    assign five_sq = {s4_sq_reg, 2'b00} + {2'b00, s4_sq_reg};
    assign low     = s4_data_reg.dev[18];

    always_comb
    begin
        s5_next.raw_p = s4_data_reg.raw_p;
        s5_next.temp  = s4_data_reg.temp;
        s5_next.off   = s4_data_reg.off;
        s5_next.sens  = s4_data_reg.sens;
        if (low)
        begin
            s5_next.temp = s4_data_reg.temp - $signed({2'b00, s4_data_reg.dtsq});
            s5_next.off  = s4_data_reg.off - $signed({4'd0, five_sq[36:1]});
            s5_next.sens = s4_data_reg.sens - $signed({3'd0, five_sq[36:2]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sq_reg   <= sq_next;
        s4_data_reg <= in_data;
        s5_data_reg <= s5_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/bc_pressure.sv @@
`default_nettype none

module bc_pressure (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire bc_pkg::bc_second_t in_data,
    output logic               out_valid,
    output logic signed [14:0] temperature,
    output logic        [16:0] pressure,
    output logic               saturated
);
    import bc_pkg::*;

    // Stage 6: partial products of D1*SENS, temperature clamp
    logic        [42:0] ppl_next;
    logic signed [43:0] pph_next;
    logic signed [14:0] temp_next;
    logic               tsat_next;
    logic        [42:0] s6_ppl_reg;
    logic signed [43:0] s6_pph_reg;
    logic signed [39:0] s6_off_reg;
    logic signed [14:0] s6_temp_reg;
    logic               s6_tsat_reg;
    logic               s6_valid_reg;

    // Stage 7: full product
    logic signed [63:0] prod_next;
    logic signed [63:0] s7_prod_reg;
    logic signed [39:0] s7_off_reg;
    logic signed [14:0] s7_temp_reg;
    logic               s7_tsat_reg;
    logic               s7_valid_reg;

    // Stage 8: D1*SENS / 2^21 - OFF
    logic signed [63:0] prod_bias;
    logic signed [42:0] q21;
    logic signed [43:0] diff_next;
    logic signed [43:0] s8_diff_reg;
    logic signed [14:0] s8_temp_reg;
    logic               s8_tsat_reg;
    logic               s8_valid_reg;

    // Stage 9: / 2^15, pressure clamp, result registers
    logic signed [43:0] diff_bias;
    logic signed [28:0] pq;
    logic        [16:0] pres_next;
    logic               psat_next;
    logic        [16:0] s9_pres_reg;
    logic signed [14:0] s9_temp_reg;
    logic               s9_sat_reg;
    logic               s9_valid_reg;

    assign ppl_next = in_data.raw_p * in_data.sens[18:0];
    // upper half of SENS carries the sign
    assign pph_next = $signed({1'b0, in_data.raw_p}) * $signed(in_data.sens[37:19]);

    always_comb
    begin
        tsat_next = 1'b1;
        if (in_data.temp < TEMP_MIN)
            temp_next = 15'(TEMP_MIN);
        else if (in_data.temp > TEMP_MAX)
            temp_next = 15'(TEMP_MAX);
        else
        begin
            temp_next = in_data.temp[14:0];
            tsat_next = 1'b0;
        end
    end

    assign prod_next = $signed({s6_pph_reg[43], s6_pph_reg, 19'd0})
                     + $signed({21'd0, s6_ppl_reg});

    // Bias negative values so the shift truncates toward zero
    assign prod_bias = s7_prod_reg + $signed({43'd0, {21{s7_prod_reg[63]}}});
    assign q21       = prod_bias[63:21];
    assign diff_next = {q21[42], q21} - {{4{s7_off_reg[39]}}, s7_off_reg};

    assign diff_bias = s8_diff_reg + $signed({29'd0, {15{s8_diff_reg[43]}}});
    assign pq        = diff_bias[43:15];

    always_comb
    begin
        psat_next = 1'b1;
        if (pq < PRES_MIN)
            pres_next = 17'(PRES_MIN);
        else if (pq > PRES_MAX)
            pres_next = 17'(PRES_MAX);
        else
        begin
            pres_next = pq[16:0];
            psat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= in_valid;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_ppl_reg  <= ppl_next;
        s6_pph_reg  <= pph_next;
        s6_off_reg  <= in_data.off;
        s6_temp_reg <= temp_next;
        s6_tsat_reg <= tsat_next;

        s7_prod_reg <= prod_next;
        s7_off_reg  <= s6_off_reg;
        s7_temp_reg <= s6_temp_reg;
        s7_tsat_reg <= s6_tsat_reg;

        s8_diff_reg <= diff_next;
        s8_temp_reg <= s7_temp_reg;
        s8_tsat_reg <= s7_tsat_reg;

        s9_pres_reg <= pres_next;
        s9_temp_reg <= s8_temp_reg;
        s9_sat_reg  <= s8_tsat_reg | psat_next;
    end

    assign out_valid   = s9_valid_reg;
    assign temperature = s9_temp_reg;
    assign pressure    = s9_pres_reg;
    assign saturated   = s9_sat_reg;

endmodule

`default_nettype wire

@@ rtl/core/barometer_compensation.sv @@
// Second-order barometer compensation. Each start beat carries one raw
// temperature and one raw pressure conversion; busy never rises, so a new
// pair may enter on every clock. The result appears with done after nine
// register stages (dT, the four products of dT, the first-order sums, the
// square of the deviation, the cold correction, the two halves of D1*SENS,
// their sum, the offset subtract and the final scale and clamp), and stays
// for one cycle only: the receiver cannot hold it off. The six calibration
// words reset to a typical part's values and are written on the cfg
// channel; write them only while no conversion is in flight.
`default_nettype none

module barometer_compensation (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [23:0]                  raw_temperature,
    input  wire logic [23:0]                  raw_pressure,
    output logic                              done,
    output logic signed [14:0]                temperature_centi,
    output logic [16:0]                       pressure_centi,
    output logic                              saturated_flag,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                  cfg_data
);
    import bc_pkg::*;

    bc_cfg_t    cfg;
    logic       first_valid;
    bc_first_t  first_data;
    logic       second_valid;
    bc_second_t second_data;

    assign busy = 1'b0;

    bc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bc_first_order u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (start && !busy),
        .raw_t     (raw_temperature),
        .raw_p     (raw_pressure),
        .out_valid (first_valid),
        .out_data  (first_data)
    );

    bc_second_order u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (first_valid),
        .in_data   (first_data),
        .out_valid (second_valid),
        .out_data  (second_data)
    );

    bc_pressure u_pressure (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (second_valid),
        .in_data     (second_data),
        .out_valid   (done),
        .temperature (temperature_centi),
        .pressure    (pressure_centi),
        .saturated   (saturated_flag)
    );

endmodule

`default_nettype wire

@@ rtl/core/bc_checker.sv @@
`default_nettype none

module bc_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic                         done,
    input  wire logic signed [14:0]           temperature_centi,
    input  wire logic [16:0]                  pressure_centi,
    input  wire logic                         saturated_flag
);
    import bc_pkg::*;

    // Every accepted beat yields a result after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat produced no result");

    // No result without a beat accepted that many cycles before
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching beat");

    // Results always stay inside the rated range
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (temperature_centi >= TEMP_MIN && temperature_centi <= TEMP_MAX
                  && pressure_centi >= PRES_MIN && pressure_centi <= PRES_MAX))
        else $error("result outside rated range");

    // A clamped value sits on a bound, so values strictly inside never flag
    a_sat_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && temperature_centi > TEMP_MIN && temperature_centi < TEMP_MAX
              && pressure_centi > PRES_MIN && pressure_centi < PRES_MAX)
        |-> !saturated_flag)
        else $error("saturation flagged on an unclamped result");

endmodule

bind barometer_compensation bc_checker u_bc_checker (.*);

`default_nettype wire

@@ tb/sv/barometer_compensation_tb.sv @@
`timescale 1ns / 1ps

module barometer_compensation_tb;

    import bc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint TEMP_SCALE = 64'sd8388608;
    localparam longint OFF_SCALE  = 64'sd65536;
    localparam longint OFF_DIV    = 64'sd128;
    localparam longint SENS_SCALE = 64'sd32768;
    localparam longint SENS_DIV   = 64'sd256;
    localparam longint DTSQ_DIV   = 64'sd2147483648;
    localparam longint PROD_DIV   = 64'sd2097152;
    localparam longint PRES_DIV   = 64'sd32768;

    localparam int RANDOM_ITEMS = 1560;
    localparam int CHUNKS       = 4;

    typedef enum int {CAL_RESET, CAL_NEAR, CAL_WILD} cal_kind_t;

    typedef struct packed {
        logic signed [14:0] temp;
        logic        [16:0] pres;
        logic               sat;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [23:0]          raw_temperature;
    logic [23:0]          raw_pressure;
    logic                 done;
    logic signed [14:0]   temperature_centi;
    logic [16:0]          pressure_centi;
    logic                 saturated_flag;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    logic [15:0] cal_words [0:5];
    reading_t    compensated_q [$];
    int          mismatch_count = 0;
    int          gap_pct = 0;

    barometer_compensation DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .raw_temperature   (raw_temperature),
        .raw_pressure      (raw_pressure),
        .done              (done),
        .temperature_centi (temperature_centi),
        .pressure_centi    (pressure_centi),
        .saturated_flag    (saturated_flag),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic reading_t compensate(input logic [23:0] rt, input logic [23:0] rp);
        longint   c1, c2, c3, c4, c5, c6;
        longint   d1, d2, dt, temp, off, sens, pres, dev, sq;
        reading_t r;
        c1 = cal_words[REG_SENS];
        c2 = cal_words[REG_OFFSET];
        c3 = cal_words[REG_SENS_TEMP];
        c4 = cal_words[REG_OFFSET_TEMP];
        c5 = cal_words[REG_REF_TEMP];
        c6 = cal_words[REG_TEMP_SLOPE];
        d2 = rt;
        d1 = rp;
        r.sat = 1'b0;

        dt   = d2 - c5 * 256;
        temp = TEMP_BASE + (dt * c6) / TEMP_SCALE;
        off  = c2 * OFF_SCALE + (c4 * dt) / OFF_DIV;
        sens = c1 * SENS_SCALE + (c3 * dt) / SENS_DIV;

        // cold branch keys off the first-order temperature
        if (temp < TEMP_BASE)
        begin
            dev  = temp - TEMP_BASE;
            sq   = dev * dev;
            temp = temp - (dt * dt) / DTSQ_DIV;
            off  = off - (5 * sq) / 2;
            sens = sens - (5 * sq) / 4;
        end

        pres = ((d1 * sens) / PROD_DIV - off) / PRES_DIV;

        if (temp < TEMP_MIN)
        begin
            temp  = TEMP_MIN;
            r.sat = 1'b1;
        end
        if (temp > TEMP_MAX)
        begin
            temp  = TEMP_MAX;
            r.sat = 1'b1;
        end
        if (pres < PRES_MIN)
        begin
            pres  = PRES_MIN;
            r.sat = 1'b1;
        end
        if (pres > PRES_MAX)
        begin
            pres  = PRES_MAX;
            r.sat = 1'b1;
        end
        r.temp = temp[14:0];
        r.pres = pres[16:0];
        return r;
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] w);
        int j;
        int v;
        j = $urandom_range(8000);
        v = w + j - 4000;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // one result beat per done; the receiver has no way to stall it
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done)
        begin
            if (compensated_q.size() == 0)
            begin
                $display("%0t: result with nothing pending: temp %0d pres %0d sat %0b",
                         $time, temperature_centi, pressure_centi, saturated_flag);
                mismatch_count++;
            end
            else
            begin
                want = compensated_q.pop_front();
                if (temperature_centi !== want.temp)
                begin
                    $display("%0t: temperature_centi expected %0d got %0d",
                             $time, want.temp, temperature_centi);
                    mismatch_count++;
                end
                if (pressure_centi !== want.pres)
                begin
                    $display("%0t: pressure_centi expected %0d got %0d",
                             $time, want.pres, pressure_centi);
                    mismatch_count++;
                end
                if (saturated_flag !== want.sat)
                begin
                    $display("%0t: saturated_flag expected %0b got %0b",
                             $time, want.sat, saturated_flag);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_reading(input logic [23:0] rt, input logic [23:0] rp);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        start           <= 1'b1;
        raw_temperature <= rt;
        raw_pressure    <= rp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        compensated_q.push_back(compensate(rt, rp));
    endtask

    // drop start and hold off until every pending result is back
    task automatic drain_readings();
        @(negedge clk);
        start <= 1'b0;
        while (compensated_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= REG_TEMP_SLOPE)
            cal_words[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(input logic [15:0] c1, input logic [15:0] c2,
                            input logic [15:0] c3, input logic [15:0] c4,
                            input logic [15:0] c5, input logic [15:0] c6);
        drain_readings();
        write_cal(REG_SENS, c1);
        write_cal(REG_OFFSET, c2);
        write_cal(REG_SENS_TEMP, c3);
        write_cal(REG_OFFSET_TEMP, c4);
        write_cal(REG_REF_TEMP, c5);
        write_cal(REG_TEMP_SLOPE, c6);
    endtask

    task automatic send_corners();
        send_reading(24'h000000, 24'h000000);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h000000, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'h000000);
        send_reading(24'h82B800, 24'h8AA21A);
    endtask

    // reset calibration: C5*256 = 8566784 puts the first-order temp at 2000
    task automatic test_corner_readings();
        gap_pct = 0;
        send_corners();
        send_reading(24'd8566784, 24'd9085466);
        send_reading(24'd8566783, 24'd9085466);
        send_reading(24'd8566487, 24'd9085466);
        send_reading(24'd8569150, 24'd9085466);
        send_reading(24'd8000000, 24'd9085466);
        send_reading(24'd7000000, 24'd9085466);
        send_reading(24'd9500000, 24'd9085466);
        send_reading(24'd8569150, 24'd1);
        send_reading(24'd8569150, 24'd16000000);
        send_reading(24'hAAAAAA, 24'h555555);
        send_reading(24'h555555, 24'hAAAAAA);
    endtask

    task automatic test_cal_extremes();
        load_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_corners();
        load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_corners();
        load_cal(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_corners();
    endtask

    // writes past the last register must leave the calibration alone
    task automatic test_spare_index();
        load_cal(RST_SENS, RST_OFFSET, RST_SENS_TEMP, RST_OFFSET_TEMP,
                 RST_REF_TEMP, RST_TEMP_SLOPE);
        write_cal(REG_SPARE_A, 16'(($urandom())));
        write_cal(REG_SPARE_B, 16'hFFFF);
        send_corners();
    endtask

    task automatic load_kind(input cal_kind_t kind);
        case (kind)
            CAL_RESET:
                load_cal(RST_SENS, RST_OFFSET, RST_SENS_TEMP, RST_OFFSET_TEMP,
                         RST_REF_TEMP, RST_TEMP_SLOPE);
            CAL_NEAR:
                load_cal(jitter(RST_SENS), jitter(RST_OFFSET), jitter(RST_SENS_TEMP),
                         jitter(RST_OFFSET_TEMP), jitter(RST_REF_TEMP),
                         jitter(RST_TEMP_SLOPE));
            default:
                load_cal(16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()), 16'($urandom()), 16'($urandom()));
        endcase
    endtask

    task automatic test_random_stream(input int pct, input int count);
        int          v;
        logic [23:0] rt;
        logic [23:0] rp;
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            case (chunk)
                0: load_kind(CAL_RESET);
                2: load_kind(CAL_WILD);
                default: load_kind(CAL_NEAR);
            endcase
            gap_pct = pct;
            for (int i = 0; i < count / CHUNKS; i++)
            begin
                if ($urandom_range(99) < 70)
                begin
                    // around the reference temperature, plausible pressure
                    v = cal_words[REG_REF_TEMP] * 256 + $urandom_range(4194304) - 2097152;
                    if (v < 0)
                        v = 0;
                    if (v > 16777215)
                        v = 16777215;
                    rt = v[23:0];
                    rp = 24'($urandom_range(12000000, 3000000));
                end
                else
                begin
                    rt = 24'($urandom());
                    rp = 24'($urandom());
                end
                send_reading(rt, rp);
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        raw_temperature = '0;
        raw_pressure    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        cal_words[REG_SENS]        = RST_SENS;
        cal_words[REG_OFFSET]      = RST_OFFSET;
        cal_words[REG_SENS_TEMP]   = RST_SENS_TEMP;
        cal_words[REG_OFFSET_TEMP] = RST_OFFSET_TEMP;
        cal_words[REG_REF_TEMP]    = RST_REF_TEMP;
        cal_words[REG_TEMP_SLOPE]  = RST_TEMP_SLOPE;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_readings();
        test_cal_extremes();
        test_spare_index();
        test_random_stream(11, RANDOM_ITEMS / 3);
        test_random_stream(62, RANDOM_ITEMS / 3);
        test_random_stream(0, RANDOM_ITEMS / 3);

        drain_readings();
        repeat (LATENCY + 2)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bc_pkg.sv
rtl/core/bc_cfg_regs.sv
rtl/core/bc_first_order.sv
rtl/core/bc_second_order.sv
rtl/core/bc_pressure.sv
rtl/core/barometer_compensation.sv
rtl/core/bc_checker.sv
tb/sv/barometer_compensation_tb.sv
